/* hw/rtl/polyblep_oscillator_macros.svh */
// assertion macros for the polyblep oscillator
`ifndef POLYBLEP_OSCILLATOR_MACROS_SVH
`define POLYBLEP_OSCILLATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define PBL_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PBL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/pblosc_pkg.sv */
// shared types and constants for the polyblep oscillator
`timescale 1ns / 1ps

package pblosc_pkg;

    // default parameter values
    localparam int PHASE_BITS_DEF     = 24;
    localparam int SINE_ADDR_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF    = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_TYPE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = CFG_IDX_W'(2);

    localparam int WAVE_W = 2;
    typedef enum logic [WAVE_W-1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_SAW    = 2'd1,
        WAVE_SQUARE = 2'd2
    } wave_t;

    localparam int GAIN_W = 16;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

    // fixed-point formats
    localparam int FRAC_BITS = 30;
    localparam int ACC_W     = 34;
    localparam logic signed [ACC_W-1:0] ACC_ONE = ACC_W'(1) <<< FRAC_BITS;
    localparam int T_W = FRAC_BITS + 1;
    localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;

    // shared multiplier
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SCL_W  = MUL_W + GAIN_W + 1;

    // sine series: quarter-wave angle and odd-term divisors with reciprocals
    localparam logic [MUL_W-1:0] HALF_PI_Q30 = 32'd1686629713;
    localparam int SER_TERMS       = 5;
    localparam int TERM_W          = $clog2(SER_TERMS);
    localparam int SER_DIV_W       = 7;
    localparam int SER_RECIP_SHIFT = 33;
    localparam logic [SER_DIV_W-1:0] SER_DIVISOR [0:SER_TERMS-1] = '{
        7'd110, 7'd72, 7'd42, 7'd20, 7'd6
    };
    localparam logic [MUL_W-1:0] SER_RECIP [0:SER_TERMS-1] = '{
        32'((64'd1 << SER_RECIP_SHIFT) / 64'd110),
        32'((64'd1 << SER_RECIP_SHIFT) / 64'd72),
        32'((64'd1 << SER_RECIP_SHIFT) / 64'd42),
        32'((64'd1 << SER_RECIP_SHIFT) / 64'd20),
        32'((64'd1 << SER_RECIP_SHIFT) / 64'd6)
    };

    // polyblep ratio divider, two quotient bits per cycle
    localparam int U_BITS    = 30;
    localparam int DIV_STEPS = U_BITS / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SIN_X,
        ST_SIN_X2,
        ST_SIN_TQ,
        ST_SIN_EST,
        ST_SIN_CHK,
        ST_SIN_FIX,
        ST_SIN_FIN,
        ST_SIN_V,
        ST_BLP_CHK,
        ST_BLP_DIV,
        ST_BLP_SQ,
        ST_SCALE,
        ST_ROUND
    } state_t;

endpackage

/* hw/rtl/pblosc_mul.sv */
// shared 32x32 unsigned multiplier with registered product
`timescale 1ns / 1ps

module pblosc_mul (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [pblosc_pkg::MUL_W-1:0]   a,
    input  logic [pblosc_pkg::MUL_W-1:0]   b,
    output logic [pblosc_pkg::PROD_W-1:0]  prod
);

    logic [pblosc_pkg::PROD_W-1:0] prod_reg;
    logic [pblosc_pkg::PROD_W-1:0] prod_next;

    assign prod_next = pblosc_pkg::PROD_W'(a) * pblosc_pkg::PROD_W'(b);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

/* hw/rtl/pblosc_div.sv */
// radix-4 restoring divider for the polyblep ratio dist/increment in Q30
`timescale 1ns / 1ps

module pblosc_div #(
    parameter int PHASE_BITS = pblosc_pkg::PHASE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [PHASE_BITS-2:0]           dividend,
    input  logic [PHASE_BITS-2:0]           divisor,
    output logic                            done,
    output logic [pblosc_pkg::U_BITS-1:0]   quotient
);

    localparam int DEN_W = PHASE_BITS - 1;
    localparam int REM_W = PHASE_BITS;
    localparam int CW    = pblosc_pkg::DIV_CNT_W;
    localparam int QW    = pblosc_pkg::U_BITS;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [QW-1:0]    quo_reg, quo_next;

    logic [REM_W-1:0] den_ext;
    logic [REM_W-1:0] sh1, r1, sh2, r2;
    logic             ge1, ge2;

    // remainder stays below the divisor, so its top bit is always clear before a shift
    assign den_ext = {1'b0, den_reg};
    assign sh1     = {rem_reg[REM_W-2:0], 1'b0};
    assign ge1     = sh1 >= den_ext;
    assign r1      = ge1 ? sh1 - den_ext : sh1;
    assign sh2     = {r1[REM_W-2:0], 1'b0};
    assign ge2     = sh2 >= den_ext;
    assign r2      = ge2 ? sh2 - den_ext : sh2;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = {1'b0, dividend};
            den_next  = divisor;
            quo_next  = '0;
        end else if (busy_reg) begin
            rem_next = r2;
            quo_next = {quo_reg[QW-3:0], ge1, ge2};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(pblosc_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hw/rtl/polyblep_oscillator.sv */
// polyblep oscillator top level: config registers, sequencer, shared units, output register
// each polyblep correction is one divider pass plus one multiplier pass; the sine series
// runs x, x squared, a product, reciprocal estimate and check per term, and x times the
// series through the shared 32x32 multiplier
// a request is taken only while idle, after the last result is written; a waiting result does not block a request
// synchronous active-low reset clears phase and control, loads wave 0, increment 0, gain unity
`timescale 1ns / 1ps
`include "polyblep_oscillator_macros.svh"

module polyblep_oscillator #(
    parameter int PHASE_BITS           = pblosc_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_ADDR_BITS = pblosc_pkg::SINE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS          = pblosc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [pblosc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pblosc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_phase_restart,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [SAMPLE_BITS-1:0]       m_sample_out
);

    localparam int PB        = PHASE_BITS;
    localparam int INC_W     = PHASE_BITS - 1;
    localparam int AW        = SINE_TABLE_ADDR_BITS;
    localparam int PQ_SHIFT  = 32 - PHASE_BITS;
    localparam int OUT_SHIFT = 45 - SAMPLE_BITS;
    localparam int ACC_W     = pblosc_pkg::ACC_W;
    localparam int MUL_W     = pblosc_pkg::MUL_W;
    localparam int PROD_W    = pblosc_pkg::PROD_W;
    localparam int SCL_W     = pblosc_pkg::SCL_W;
    localparam int FRAC      = pblosc_pkg::FRAC_BITS;
    localparam int T_W       = pblosc_pkg::T_W;
    localparam int TW        = pblosc_pkg::TERM_W;
    localparam int UW        = pblosc_pkg::U_BITS;
    localparam int RS        = pblosc_pkg::SER_RECIP_SHIFT;

    localparam logic [PB:0] PH_ONE = {1'b1, {PB{1'b0}}};
    localparam logic [AW:0] ROM_N  = {1'b1, {AW{1'b0}}};
    localparam logic signed [SCL_W-1:0] RND_HALF = SCL_W'(1) <<< (OUT_SHIFT - 1);
    localparam logic signed [SCL_W-1:0] OUT_MAX  = (SCL_W'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [SCL_W-1:0] OUT_MIN  = -OUT_MAX - 1;

    // configuration registers
    logic [pblosc_pkg::WAVE_W-1:0] wave_reg;
    logic [INC_W-1:0]              inc_reg;
    logic [pblosc_pkg::GAIN_W-1:0] gain_reg;

    // sequencer and datapath registers
    pblosc_pkg::state_t state_reg, state_next;
    logic [PB-1:0]            phase_reg, phase_next;
    logic [PB-1:0]            p_reg, p_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [MUL_W-1:0]         x_reg, x_next;
    logic [MUL_W-1:0]         x2_reg, x2_next;
    logic [T_W-1:0]           t_reg, t_next;
    logic [MUL_W-1:0]         q_reg, q_next;
    logic [FRAC-1:0]          est_reg, est_next;
    logic [TW-1:0]            term_reg, term_next;
    logic                     bsel_reg, bsel_next;
    logic                     bend_reg, bend_next;
    logic                     m_valid_reg, m_valid_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;

    // shared units
    logic                mul_en;
    logic [MUL_W-1:0]    mul_a, mul_b;
    logic [PROD_W-1:0]   prod;
    logic                div_start;
    logic [INC_W-1:0]    div_dividend;
    logic                div_done;
    logic [UW-1:0]       div_quo;

    // combinational helpers
    logic [PB-1:0]            in_phase;
    logic [1:0]               quad;
    logic [AW-1:0]            sin_idx;
    logic [AW:0]              sin_k;
    logic [31:0]              pq_shift;
    logic signed [ACC_W-1:0]  saw_init;
    logic signed [ACC_W-1:0]  sqr_init;
    logic [PB-1:0]            blep_t;
    logic                     inc_zero;
    logic                     is_start;
    logic                     is_end;
    logic [PB:0]              one_minus_dt;
    logic [PB:0]              dist_end;
    logic [UW-1:0]            u_sq;
    logic signed [ACC_W-1:0]  blep_start;
    logic signed [ACC_W-1:0]  blep_val;
    logic                     blep_sub;
    logic signed [ACC_W-1:0]  acc_blep;
    logic                     blep_more;
    logic [MUL_W-1:0]         prod_q30;
    logic [MUL_W:0]           fix_rem;
    logic                     fix_up;
    logic [FRAC-1:0]          est_fix;
    logic [T_W-1:0]           t_fix;
    logic [T_W-1:0]           sin_v;
    logic signed [ACC_W-1:0]  sin_signed;
    logic signed [ACC_W-1:0]  acc_abs;
    logic [SCL_W-2:0]         scl_mag;
    logic signed [SCL_W-1:0]  scl_signed;
    logic signed [SCL_W-1:0]  scl_rnd;
    logic signed [SCL_W-1:0]  scl_shift;
    logic signed [SAMPLE_BITS-1:0] sample_sat;

    pblosc_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    pblosc_div #(
        .PHASE_BITS (PHASE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (inc_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign in_phase = s_phase_restart ? '0 : phase_reg;

    // quarter-wave lookup index, mirrored in the odd quadrants
    assign quad    = p_reg[PB-1:PB-2];
    assign sin_idx = p_reg[PB-3 -: AW];
    assign sin_k   = quad[0] ? ROM_N - {1'b0, sin_idx} : {1'b0, sin_idx};

    assign pq_shift = 32'(p_reg) << PQ_SHIFT;
    assign saw_init = $signed(ACC_W'({pq_shift[31:2], 1'b0})) - pblosc_pkg::ACC_ONE;
    assign sqr_init = p_reg[PB-1] ? -pblosc_pkg::ACC_ONE : pblosc_pkg::ACC_ONE;

    // second square correction looks at the phase plus half a cycle
    assign blep_t       = {p_reg[PB-1] ^ bsel_reg, p_reg[PB-2:0]};
    assign inc_zero     = inc_reg == '0;
    assign is_start     = blep_t < {1'b0, inc_reg};
    assign one_minus_dt = PH_ONE - {2'b00, inc_reg};
    assign is_end       = {1'b0, blep_t} > one_minus_dt;
    assign dist_end     = PH_ONE - {1'b0, blep_t};

    assign u_sq       = prod[FRAC +: UW];
    assign blep_start = $signed(ACC_W'({div_quo, 1'b0})) - $signed(ACC_W'(u_sq))
                        - pblosc_pkg::ACC_ONE;
    assign blep_val   = bend_reg ? -blep_start : blep_start;
    assign blep_sub   = (wave_reg == pblosc_pkg::WAVE_SAW) || bsel_reg;
    assign acc_blep   = blep_sub ? acc_reg - blep_val : acc_reg + blep_val;
    assign blep_more  = (wave_reg == pblosc_pkg::WAVE_SQUARE) && !bsel_reg;

    // series term: floor(q/d) by reciprocal estimate plus one correction
    assign prod_q30   = prod[FRAC +: MUL_W];
    assign fix_rem    = {1'b0, q_reg} - prod[MUL_W:0];
    assign fix_up     = fix_rem >= (MUL_W + 1)'(pblosc_pkg::SER_DIVISOR[term_reg]);
    assign est_fix    = est_reg + FRAC'(fix_up);
    assign t_fix      = pblosc_pkg::T_ONE - {1'b0, est_fix};
    assign sin_v      = prod[FRAC +: T_W];
    assign sin_signed = p_reg[PB-1] ? -$signed(ACC_W'(sin_v)) : $signed(ACC_W'(sin_v));

    // gain, round half up, saturate
    assign acc_abs    = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
    assign scl_mag    = prod[SCL_W-2:0];
    assign scl_signed = acc_reg[ACC_W-1] ? -$signed({1'b0, scl_mag}) : $signed({1'b0, scl_mag});
    assign scl_rnd    = scl_signed + RND_HALF;
    assign scl_shift  = scl_rnd >>> OUT_SHIFT;
    assign sample_sat = (scl_shift > OUT_MAX) ? OUT_MAX[SAMPLE_BITS-1:0] :
                        (scl_shift < OUT_MIN) ? OUT_MIN[SAMPLE_BITS-1:0] :
                        scl_shift[SAMPLE_BITS-1:0];

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        p_next       = p_reg;
        acc_next     = acc_reg;
        x_next       = x_reg;
        x2_next      = x2_reg;
        t_next       = t_reg;
        q_next       = q_reg;
        est_next     = est_reg;
        term_next    = term_reg;
        bsel_next    = bsel_reg;
        bend_next    = bend_reg;
        sample_next  = sample_reg;
        m_valid_next = m_valid_reg && !m_ready;
        mul_en       = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = '0;
        case (state_reg)
            pblosc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    p_next     = in_phase;
                    phase_next = in_phase + PB'(inc_reg);
                    state_next = pblosc_pkg::ST_INIT;
                end
            end
            pblosc_pkg::ST_INIT: begin
                bsel_next = 1'b0;
                case (wave_reg)
                    pblosc_pkg::WAVE_SINE: begin
                        mul_en     = 1'b1;
                        mul_a      = pblosc_pkg::HALF_PI_Q30;
                        mul_b      = MUL_W'(sin_k);
                        state_next = pblosc_pkg::ST_SIN_X;
                    end
                    pblosc_pkg::WAVE_SAW: begin
                        acc_next   = saw_init;
                        state_next = pblosc_pkg::ST_BLP_CHK;
                    end
                    pblosc_pkg::WAVE_SQUARE: begin
                        acc_next   = sqr_init;
                        state_next = pblosc_pkg::ST_BLP_CHK;
                    end
                    default: begin
                        acc_next   = '0;
                        state_next = pblosc_pkg::ST_SCALE;
                    end
                endcase
            end
            pblosc_pkg::ST_SIN_X: begin
                x_next     = prod[AW +: MUL_W];
                mul_en     = 1'b1;
                mul_a      = prod[AW +: MUL_W];
                mul_b      = prod[AW +: MUL_W];
                state_next = pblosc_pkg::ST_SIN_X2;
            end
            pblosc_pkg::ST_SIN_X2: begin
                x2_next    = prod_q30;
                t_next     = pblosc_pkg::T_ONE;
                term_next  = '0;
                state_next = pblosc_pkg::ST_SIN_TQ;
            end
            pblosc_pkg::ST_SIN_TQ: begin
                mul_en     = 1'b1;
                mul_a      = x2_reg;
                mul_b      = MUL_W'(t_reg);
                state_next = pblosc_pkg::ST_SIN_EST;
            end
            pblosc_pkg::ST_SIN_EST: begin
                q_next     = prod_q30;
                mul_en     = 1'b1;
                mul_a      = prod_q30;
                mul_b      = pblosc_pkg::SER_RECIP[term_reg];
                state_next = pblosc_pkg::ST_SIN_CHK;
            end
            pblosc_pkg::ST_SIN_CHK: begin
                est_next   = prod[RS +: FRAC];
                mul_en     = 1'b1;
                mul_a      = MUL_W'(prod[RS +: FRAC]);
                mul_b      = MUL_W'(pblosc_pkg::SER_DIVISOR[term_reg]);
                state_next = pblosc_pkg::ST_SIN_FIX;
            end
            pblosc_pkg::ST_SIN_FIX: begin
                t_next    = t_fix;
                term_next = term_reg + TW'(1);
                if (term_reg == TW'(pblosc_pkg::SER_TERMS - 1)) begin
                    state_next = pblosc_pkg::ST_SIN_FIN;
                end else begin
                    state_next = pblosc_pkg::ST_SIN_TQ;
                end
            end
            pblosc_pkg::ST_SIN_FIN: begin
                mul_en     = 1'b1;
                mul_a      = x_reg;
                mul_b      = MUL_W'(t_reg);
                state_next = pblosc_pkg::ST_SIN_V;
            end
            pblosc_pkg::ST_SIN_V: begin
                acc_next   = sin_signed;
                state_next = pblosc_pkg::ST_SCALE;
            end
            pblosc_pkg::ST_BLP_CHK: begin
                if (!inc_zero && is_start) begin
                    div_start    = 1'b1;
                    div_dividend = blep_t[INC_W-1:0];
                    bend_next    = 1'b0;
                    state_next   = pblosc_pkg::ST_BLP_DIV;
                end else if (!inc_zero && is_end) begin
                    div_start    = 1'b1;
                    div_dividend = dist_end[INC_W-1:0];
                    bend_next    = 1'b1;
                    state_next   = pblosc_pkg::ST_BLP_DIV;
                end else if (blep_more) begin
                    bsel_next = 1'b1;
                end else begin
                    state_next = pblosc_pkg::ST_SCALE;
                end
            end
            pblosc_pkg::ST_BLP_DIV: begin
                if (div_done) begin
                    mul_en     = 1'b1;
                    mul_a      = MUL_W'(div_quo);
                    mul_b      = MUL_W'(div_quo);
                    state_next = pblosc_pkg::ST_BLP_SQ;
                end
            end
            pblosc_pkg::ST_BLP_SQ: begin
                acc_next = acc_blep;
                if (blep_more) begin
                    bsel_next  = 1'b1;
                    state_next = pblosc_pkg::ST_BLP_CHK;
                end else begin
                    state_next = pblosc_pkg::ST_SCALE;
                end
            end
            pblosc_pkg::ST_SCALE: begin
                mul_en     = 1'b1;
                mul_a      = acc_abs[MUL_W-1:0];
                mul_b      = MUL_W'(gain_reg);
                state_next = pblosc_pkg::ST_ROUND;
            end
            pblosc_pkg::ST_ROUND: begin
                // hold here while the previous result is still unclaimed
                if (!m_valid_reg || m_ready) begin
                    sample_next  = sample_sat;
                    m_valid_next = 1'b1;
                    state_next   = pblosc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pblosc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_reg <= pblosc_pkg::WAVE_SINE;
            inc_reg  <= '0;
            gain_reg <= pblosc_pkg::GAIN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pblosc_pkg::CFG_WAVE_TYPE: begin
                    wave_reg <= cfg_data[pblosc_pkg::WAVE_W-1:0];
                end
                pblosc_pkg::CFG_PHASE_INC: begin
                    inc_reg <= INC_W'(cfg_data);
                end
                pblosc_pkg::CFG_GAIN: begin
                    gain_reg <= cfg_data[pblosc_pkg::GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pblosc_pkg::ST_IDLE;
            phase_reg   <= '0;
            term_reg    <= '0;
            bsel_reg    <= 1'b0;
            bend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            term_reg    <= term_next;
            bsel_reg    <= bsel_next;
            bend_reg    <= bend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg      <= p_next;
        acc_reg    <= acc_next;
        x_reg      <= x_next;
        x2_reg     <= x2_next;
        t_reg      <= t_next;
        q_reg      <= q_next;
        est_reg    <= est_next;
        sample_reg <= sample_next;
    end

    assign s_ready      = state_reg == pblosc_pkg::ST_IDLE;
    assign m_valid      = m_valid_reg;
    assign m_sample_out = sample_reg;

    `PBL_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "ready stayed high after a request was accepted")
    `PBL_ASSERT_SAME(a_div_done_in_wait, aclk, aresetn, div_done, state_reg == pblosc_pkg::ST_BLP_DIV, "divider finished outside its wait state")
    `PBL_ASSERT_NEXT(a_phase_step, aclk, aresetn, s_valid && s_ready, phase_reg == ($past(s_phase_restart) ? '0 : $past(phase_reg)) + PB'($past(inc_reg)), "phase did not advance by the increment")

endmodule

/* bench/tb_top.sv */
// self-checking bench for the polyblep oscillator: sine, saw, square and the unused wave code
`timescale 1ns / 1ps

module tb_top;
    import pblosc_pkg::*;

    localparam int PH_W         = PHASE_BITS_DEF;
    localparam int INC_W        = PH_W - 1;
    localparam int ROM_AB       = SINE_ADDR_BITS_DEF;
    localparam int ROM_N        = 1 << ROM_AB;
    localparam int SMP_W        = SAMPLE_BITS_DEF;
    localparam int OUT_SHIFT    = 45 - SMP_W;
    localparam int PH_TO_Q30    = 30 - PH_W;
    localparam longint Q30_UNIT   = longint'(1) << 30;
    localparam longint ROUND_HALF = longint'(1) << (OUT_SHIFT - 1);
    localparam longint SMP_MAX    = (longint'(1) << (SMP_W - 1)) - 1;
    localparam longint SMP_MIN    = -(longint'(1) << (SMP_W - 1));
    localparam longint unsigned PH_ONE = longint'(1) << PH_W;
    localparam logic [PH_W-1:0] PH_HALF = PH_W'(1) << (PH_W - 1);
    localparam logic [INC_W-1:0] INC_MAX = '1;
    localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
    localparam logic [WAVE_W-1:0] WAVE_UNUSED = 2'd3;
    localparam int LATENCY_WAIT = 45;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1750;
    localparam int HOLD_CYCLES  = 500;
    localparam int PRINT_CAP    = 200;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_phase_restart = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [SMP_W-1:0] m_sample_out;

    // oscillator state as the bench tracks it
    logic [WAVE_W-1:0] wave_cfg = WAVE_SINE;
    logic [INC_W-1:0] inc_cfg = '0;
    logic [GAIN_W-1:0] gain_cfg = GAIN_RESET;
    logic [PH_W-1:0] phase_acc = '0;
    longint sine_tab [0:ROM_N];

    logic pending [$];
    logic signed [SMP_W-1:0] sample_expect_q [$];

    int errors = 0;
    int samples_seen = 0;
    int cycles = 0;
    int gap_left = 0;
    int burst_left = 0;
    int stall_left = 0;
    int stall_mode = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    polyblep_oscillator dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_phase_restart (s_phase_restart),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sample_out    (m_sample_out)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // quarter-wave entry by truncated odd series up to x^11
    function automatic longint sine_entry(input int unsigned k);
        longint unsigned x, x2, t;
        x = (longint'(HALF_PI_Q30) * k) / ROM_N;
        x2 = (x * x) >> 30;
        t = Q30_UNIT;
        for (int i = 0; i < SER_TERMS; i++)
            t = Q30_UNIT - ((x2 * t) >> 30) / longint'(SER_DIVISOR[i]);
        return longint'((x * t) >> 30);
    endfunction

    function automatic longint sine_at(input logic [PH_W-1:0] p);
        logic [1:0] quad;
        int idx;
        longint v;
        quad = p[PH_W-1 -: 2];
        idx = int'(p[PH_W-3 -: ROM_AB]);
        v = quad[0] ? sine_tab[ROM_N - idx] : sine_tab[idx];
        return quad[1] ? -v : v;
    endfunction

    function automatic longint blep_q30(input logic [PH_W-1:0] p, input logic [INC_W-1:0] d);
        longint unsigned t, dt, u;
        t = p;
        dt = d;
        if (dt == 0)
            return 0;
        if (t < dt) begin
            u = (t << 30) / dt;
            return longint'(2 * u) - longint'((u * u) >> 30) - Q30_UNIT;
        end
        if (t > PH_ONE - dt) begin
            u = ((PH_ONE - t) << 30) / dt;
            return longint'((u * u) >> 30) - longint'(2 * u) + Q30_UNIT;
        end
        return 0;
    endfunction

    // sample from the phase before it advances, then step the phase
    function automatic logic signed [SMP_W-1:0] next_sample(input logic restart);
        logic [PH_W-1:0] p, opp;
        longint wave_val, scaled;
        if (restart)
            phase_acc = '0;
        p = phase_acc;
        opp = p + PH_HALF;
        case (wave_cfg)
            WAVE_SINE: wave_val = sine_at(p);
            WAVE_SAW: wave_val = 2 * (longint'(p) <<< PH_TO_Q30) - Q30_UNIT - blep_q30(p, inc_cfg);
            WAVE_SQUARE: wave_val = ((p < PH_HALF) ? Q30_UNIT : -Q30_UNIT)
                                    + blep_q30(p, inc_cfg) - blep_q30(opp, inc_cfg);
            default: wave_val = 0;
        endcase
        phase_acc = p + PH_W'(inc_cfg);
        scaled = (wave_val * longint'(gain_cfg) + ROUND_HALF) >>> OUT_SHIFT;
        if (scaled > SMP_MAX)
            scaled = SMP_MAX;
        if (scaled < SMP_MIN)
            scaled = SMP_MIN;
        return SMP_W'(scaled);
    endfunction

    // request driver: bursts of random length, random gaps between them
    always @(posedge aclk) begin
        logic offer;
        if (!aresetn) begin
            s_valid <= 1'b0;
            phase_acc = '0;
        end else begin
            offer = s_valid;
            if (s_valid && s_ready) begin
                sample_expect_q.push_back(next_sample(s_phase_restart));
                offer = 1'b0;
            end
            if (!offer) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending.size() != 0) begin
                    s_phase_restart <= pending.pop_front();
                    offer = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
                    end else begin
                        burst_left--;
                    end
                end
            end
            s_valid <= offer;
        end
    end

    // sample monitor and receiver stall pattern
    always @(posedge aclk) begin
        logic signed [SMP_W-1:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                samples_seen++;
                if (sample_expect_q.size() == 0) begin
                    errors++;
                    if (errors <= PRINT_CAP)
                        $display("%0t ns: sample with none expected, expected none, got %0d",
                                 $time, m_sample_out);
                end else begin
                    want = sample_expect_q.pop_front();
                    if (m_sample_out !== want) begin
                        errors++;
                        if (errors <= PRINT_CAP)
                            $display("%0t ns: sample_out mismatch, expected %0d, got %0d",
                                     $time, want, m_sample_out);
                    end
                end
            end
            // one long hold-off while requests keep coming, to back up the input
            if (!hold_done && samples_seen >= 600 && pending.size() > 20) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (stall_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    stall_left = $urandom_range(8, 300);
                end else begin
                    stall_left--;
                end
                case (stall_mode)
                    0, 1: m_ready <= 1'b1;
                    2: m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
    endtask

    // unused upper data bits carry noise, the registers keep only their own width
    task automatic program_osc(input logic [WAVE_W-1:0] w, input logic [INC_W-1:0] inc,
                               input logic [GAIN_W-1:0] g);
        logic [CFG_DATA_W-1:0] noise;
        noise = CFG_DATA_W'($urandom);
        write_reg(CFG_WAVE_TYPE, {noise[CFG_DATA_W-1:WAVE_W], w});
        write_reg(CFG_PHASE_INC, inc);
        write_reg(CFG_GAIN, {noise[CFG_DATA_W-1:GAIN_W], g});
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        wave_cfg = w;
        inc_cfg = inc;
        gain_cfg = g;
    endtask

    task automatic drain_samples();
        while (pending.size() != 0 || s_valid || sample_expect_q.size() != 0)
            @(posedge aclk);
        repeat (LATENCY_WAIT) @(posedge aclk);
    endtask

    initial begin
        int random_items;
        int n;
        int odds;
        int pick;
        logic [WAVE_W-1:0] w;
        logic [INC_W-1:0] inc;
        logic [GAIN_W-1:0] g;

        for (int k = 0; k <= ROM_N; k++)
            sine_tab[k] = sine_entry(k);
        random_items = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // register defaults: sine, zero increment so the phase stands still
        pending.push_back(1'b1);
        pending.push_back(1'b0);
        drain_samples();

        // sine in eighth-period steps through all quadrants, peak hits full scale
        program_osc(WAVE_SINE, INC_W'(1) << (PH_W - 3), GAIN_RESET);
        pending.push_back(1'b1);
        repeat (8) pending.push_back(1'b0);
        drain_samples();

        // largest increment: corrections at both ends of the cycle, max gain
        program_osc(WAVE_SAW, INC_MAX, GAIN_MAX);
        repeat (3) pending.push_back(1'b0);
        drain_samples();

        program_osc(WAVE_SQUARE, INC_MAX, GAIN_RESET);
        pending.push_back(1'b1);
        repeat (2) pending.push_back(1'b0);
        drain_samples();

        // unused wave code gives silence while the phase advances
        program_osc(WAVE_UNUSED, INC_W'(12345), GAIN_MAX);
        repeat (2) pending.push_back(1'b0);
        drain_samples();

        program_osc(WAVE_SAW, '0, '0);
        pending.push_back(1'b0);
        pending.push_back(1'b1);
        drain_samples();

        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            w = (pick < 3) ? WAVE_SINE : (pick < 6) ? WAVE_SAW : (pick < 9) ? WAVE_SQUARE
                                                                            : WAVE_UNUSED;
            case ($urandom_range(0, 7))
                0: inc = '0;
                1: inc = INC_MAX;
                2: inc = INC_W'($urandom_range(1, 4096));
                3: inc = INC_W'($urandom_range(1 << (INC_W - 1), (1 << INC_W) - 1));
                default: inc = INC_W'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0: g = '0;
                1: g = GAIN_MAX;
                2: g = GAIN_RESET;
                default: g = GAIN_W'($urandom);
            endcase
            program_osc(w, inc, g);
            n = $urandom_range(20, 120);
            odds = ($urandom_range(0, 3) == 0) ? 2 : 16;
            for (int i = 0; i < n; i++)
                pending.push_back($urandom_range(0, odds - 1) == 0);
            random_items += n;
            drain_samples();
        end

        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
